// ===== src/kpi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_pkg: shared types and constants
// Beat formats, keyframe header layout, interpolation coefficients and the
// state encodings of the keyframe pose interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

  localparam int CoefW = 22;
  localparam int AccW  = 42;
  localparam int TW    = 17;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ANGLE  = 2'd1;
  localparam logic [1:0] KIND_HEADER = 2'd2;

  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_SMOOTH  = 2'd1;
  localparam logic [1:0] MODE_HERMITE = 2'd2;
  localparam logic [1:0] MODE_HOLD    = 2'd3;

  // Register index 0 is keyframe_count; paddr[2] carries the index.
  localparam logic REG_KEYFRAME_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         frame_sel;
    logic [3:0]         bone_sel;
    logic signed [15:0] angle_value;
    logic [7:0]         duration_value;
    logic [1:0]         interp_mode;
    logic signed [15:0] root_x;
    logic signed [15:0] root_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         bone_index;
    logic signed [15:0] bone_angle;
    logic signed [15:0] torso_x;
    logic signed [15:0] torso_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         duration;
    logic [1:0]         mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } hdr_t;

  typedef struct packed {
    logic signed [CoefW-1:0] c_pp;
    logic signed [CoefW-1:0] c_0;
    logic signed [CoefW-1:0] c_1;
    logic signed [CoefW-1:0] c_n;
  } coef_t;

  typedef struct packed {
    logic       start;
    logic [7:0] tick;
    logic [7:0] dur;
    logic [1:0] mode;
  } coef_req_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DIV, CS_T2, CS_T3, CS_S, CS_COEF
  } coef_state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HDR, ST_HDRW, ST_COEF, ST_RUN, ST_EMIT, ST_ADV
  } state_t;

endpackage
`default_nettype wire

// ===== src/keyframe_pose_interpolator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_top: keyframe pose interpolator
// Keyframe table in memory, sequenced interpolation and pose output.
// ----------------------------------------------------------------------------
// Hold mode skips the read phase. The weight unit runs a bit-serial division
// of tick by duration when the tick count lies below a nonzero duration. The
// read phase covers BONES channels in linear mode and BONES+2 in smoothstep
// and Hermite mode. Each pose channel makes four reads of the single-read-port
// keyframe memories through one multiply-accumulate unit. Results leave one
// beat per cycle from a single output register while out_stall is low. Input
// beats are stalled while a tick is in progress.
// ----------------------------------------------------------------------------
module keyframe_pose_interpolator_top #(
  parameter int BONES    = 11,
  parameter int MAX_KEYS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire kpi_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kpi_pkg::out_item_t        out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int AAW = $clog2(MAX_KEYS * BONES);
  localparam int KAW = $clog2(MAX_KEYS);
  localparam int BIW = (BONES > 1) ? $clog2(BONES) : 1;
  localparam int HW  = $bits(kpi_pkg::hdr_t);

  kpi_pkg::state_t state, state_next;

  logic [4:0]         keyframe_count;
  logic [3:0]         current_key;
  logic [7:0]         tick_in_key;
  logic signed [15:0] pose_angles [BONES];
  logic signed [15:0] pose_x, pose_y;

  logic [3:0] key_cur, key_prv, key_nxt, key_nxt2;
  logic [7:0] dur;
  logic [1:0] mode;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == kpi_pkg::REG_KEYFRAME_COUNT) prdata = {27'd0, keyframe_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyframe_count <= 5'd1;
    end else if (psel && penable && pwrite && paddr[2] == kpi_pkg::REG_KEYFRAME_COUNT) begin
      keyframe_count <= pwdata[4:0];
    end
  end

  // Keyframe indexes for a new tick.
  function automatic logic [3:0] wrap_inc(input logic [3:0] k, input logic [4:0] n);
    logic [4:0] k1;
    k1 = {1'b0, k} + 5'd1;
    return (k1 == n) ? 4'd0 : k1[3:0];
  endfunction

  logic [4:0] n_eff;
  logic [3:0] cur_fix, prv_fix, nxt_fix;

  always_comb begin
    if (keyframe_count == 5'd0) n_eff = 5'd1;
    else if (keyframe_count > 5'(MAX_KEYS)) n_eff = 5'(MAX_KEYS);
    else n_eff = keyframe_count;
    cur_fix = ({1'b0, current_key} >= n_eff) ? 4'd0 : current_key;
    prv_fix = (cur_fix == 4'd0) ? 4'(n_eff - 5'd1) : 4'(cur_fix - 4'd1);
    nxt_fix = wrap_inc(cur_fix, n_eff);
  end

  logic accept;
  assign in_stall = (state != kpi_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Memories.
  logic           ang_we, hdr_we;
  logic [AAW-1:0] ang_waddr, ang_raddr;
  logic [KAW-1:0] hdr_waddr, hdr_raddr;
  logic [15:0]    ang_rdata;
  logic [HW-1:0]  hdr_rdata;
  kpi_pkg::hdr_t  hdr_wr, hdr_rd;

  assign ang_we    = accept && in_data.kind == kpi_pkg::KIND_ANGLE &&
                     32'(in_data.frame_sel) < MAX_KEYS && 32'(in_data.bone_sel) < BONES;
  assign ang_waddr = AAW'(32'(in_data.frame_sel) * BONES + 32'(in_data.bone_sel));
  assign hdr_we    = accept && in_data.kind == kpi_pkg::KIND_HEADER &&
                     32'(in_data.frame_sel) < MAX_KEYS;
  assign hdr_waddr = in_data.frame_sel[KAW-1:0];

  always_comb begin
    hdr_wr.duration = in_data.duration_value;
    hdr_wr.mode     = in_data.interp_mode;
    hdr_wr.x        = in_data.root_x;
    hdr_wr.y        = in_data.root_y;
  end
  assign hdr_rd = kpi_pkg::hdr_t'(hdr_rdata);

  kpi_ram #(.WIDTH(16), .DEPTH(MAX_KEYS * BONES)) u_ang_ram (
    .clk(clk), .we(ang_we), .waddr(ang_waddr), .wdata(in_data.angle_value),
    .raddr(ang_raddr), .rdata(ang_rdata)
  );

  kpi_ram #(.WIDTH(HW), .DEPTH(MAX_KEYS)) u_hdr_ram (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wr),
    .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  // Weight unit.
  kpi_pkg::coef_req_t coef_req;
  kpi_pkg::coef_t     coef;
  logic               coef_done;

  always_comb begin
    coef_req.start = (state == kpi_pkg::ST_HDRW);
    coef_req.tick  = tick_in_key;
    coef_req.dur   = hdr_rd.duration;
    coef_req.mode  = hdr_rd.mode;
  end

  kpi_coef u_coef (.clk(clk), .rst(rst), .req(coef_req), .done(coef_done), .coef(coef));

  // Read issue: four taps per channel; channels past the bones are x and y.
  logic [4:0] iss_chan, last_chan;
  logic [1:0] iss_tap;
  logic       iss_active;
  logic [3:0] tap_key;
  logic [4:0] ang_bone;

  assign last_chan = (mode == kpi_pkg::MODE_LINEAR) ? 5'(BONES - 1) : 5'(BONES + 1);

  always_comb begin
    case (iss_tap)
      2'd0:    tap_key = key_prv;
      2'd1:    tap_key = key_cur;
      2'd2:    tap_key = key_nxt;
      default: tap_key = key_nxt2;
    endcase
    ang_bone  = (32'(iss_chan) < BONES) ? iss_chan : 5'd0;
    ang_raddr = AAW'(32'(tap_key) * BONES + 32'(ang_bone));
    hdr_raddr = (state == kpi_pkg::ST_RUN) ? tap_key[KAW-1:0] : key_cur[KAW-1:0];
  end

  // Multiply and accumulate stages.
  logic       b_valid, c_valid;
  logic [1:0] b_tap, c_tap;
  logic [4:0] b_chan, c_chan;
  logic signed [15:0] b_data;
  logic signed [kpi_pkg::CoefW-1:0] b_coef;
  logic signed [kpi_pkg::CoefW+15:0] prod;
  logic signed [kpi_pkg::AccW-1:0] acc, sum, rsum;
  logic signed [15:0] res;

  always_comb begin
    if (32'(b_chan) < BONES) b_data = ang_rdata;
    else if (32'(b_chan) == BONES) b_data = hdr_rd.x;
    else b_data = hdr_rd.y;
    case (b_tap)
      2'd0:    b_coef = coef.c_pp;
      2'd1:    b_coef = coef.c_0;
      2'd2:    b_coef = coef.c_1;
      default: b_coef = coef.c_n;
    endcase
  end

  always_comb begin
    sum  = ((c_tap == 2'd0) ? kpi_pkg::AccW'(0) : acc) + kpi_pkg::AccW'(prod);
    rsum = (sum + kpi_pkg::AccW'(65536)) >>> 17;
    if (rsum > kpi_pkg::AccW'(32767)) res = 16'sd32767;
    else if (rsum < -kpi_pkg::AccW'(32768)) res = -16'sd32768;
    else res = 16'(rsum);
  end

  // Output beats.
  logic [3:0] emit_idx;
  logic       out_load;
  assign out_load = (state == kpi_pkg::ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      kpi_pkg::ST_IDLE:
        if (accept && in_data.kind == kpi_pkg::KIND_TICK) state_next = kpi_pkg::ST_HDR;
      kpi_pkg::ST_HDR:  state_next = kpi_pkg::ST_HDRW;
      kpi_pkg::ST_HDRW: state_next = kpi_pkg::ST_COEF;
      kpi_pkg::ST_COEF:
        if (coef_done) begin
          state_next = (mode == kpi_pkg::MODE_HOLD) ? kpi_pkg::ST_EMIT : kpi_pkg::ST_RUN;
        end
      kpi_pkg::ST_RUN:
        if (!iss_active && !b_valid && !c_valid) state_next = kpi_pkg::ST_EMIT;
      kpi_pkg::ST_EMIT:
        if (out_load && 32'(emit_idx) == BONES - 1) state_next = kpi_pkg::ST_ADV;
      kpi_pkg::ST_ADV:  state_next = kpi_pkg::ST_IDLE;
      default:          state_next = kpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kpi_pkg::ST_IDLE;
      current_key <= 4'd0;
      tick_in_key <= 8'd0;
      pose_x      <= '0;
      pose_y      <= '0;
      for (int i = 0; i < BONES; i++) pose_angles[i] <= '0;
      iss_active  <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      b_valid <= (state == kpi_pkg::ST_RUN) && iss_active;
      c_valid <= b_valid;

      if (state == kpi_pkg::ST_IDLE && state_next == kpi_pkg::ST_HDR) begin
        current_key <= cur_fix;
      end

      if (state == kpi_pkg::ST_COEF && state_next == kpi_pkg::ST_RUN) begin
        iss_active <= 1'b1;
      end else if (state == kpi_pkg::ST_RUN && iss_active && iss_tap == 2'd3 &&
                   iss_chan == last_chan) begin
        iss_active <= 1'b0;
      end

      if (c_valid && c_tap == 2'd3) begin
        if (32'(c_chan) < BONES) pose_angles[c_chan[BIW-1:0]] <= res;
        else if (32'(c_chan) == BONES) pose_x <= res;
        else pose_y <= res;
      end

      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (state == kpi_pkg::ST_ADV) begin
        if (tick_in_key >= dur) begin
          current_key <= key_nxt;
          tick_in_key <= 8'd0;
        end else begin
          tick_in_key <= tick_in_key + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == kpi_pkg::ST_IDLE) begin
      key_cur  <= cur_fix;
      key_prv  <= prv_fix;
      key_nxt  <= nxt_fix;
      key_nxt2 <= wrap_inc(nxt_fix, n_eff);
    end
    if (state == kpi_pkg::ST_HDRW) begin
      dur  <= hdr_rd.duration;
      mode <= hdr_rd.mode;
    end
    if (state == kpi_pkg::ST_COEF) begin
      iss_chan <= 5'd0;
      iss_tap  <= 2'd0;
      emit_idx <= 4'd0;
    end else if (state == kpi_pkg::ST_RUN && iss_active) begin
      iss_tap <= iss_tap + 2'd1;
      if (iss_tap == 2'd3) iss_chan <= iss_chan + 5'd1;
    end
    b_tap  <= iss_tap;
    b_chan <= iss_chan;
    c_tap  <= b_tap;
    c_chan <= b_chan;
    prod   <= b_coef * b_data;
    if (c_valid) acc <= sum;
    if (out_load) begin
      out_data.bone_index <= emit_idx;
      out_data.bone_angle <= pose_angles[emit_idx[BIW-1:0]];
      if (32'(emit_idx) == BONES - 1) begin
        out_data.torso_x <= pose_x;
        out_data.torso_y <= pose_y;
        out_data.last    <= 1'b1;
      end else begin
        out_data.torso_x <= '0;
        out_data.torso_y <= '0;
        out_data.last    <= 1'b0;
      end
      emit_idx <= emit_idx + 4'd1;
    end
  end

endmodule
`default_nettype wire

// ===== src/kpi_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_ram: generic memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/kpi_coef.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_coef: interpolation weight unit
// Divides tick by duration one quotient bit per cycle, forms t^2, t^3 and the
// smoothstep weight on one shared multiplier and folds them into four
// per-tap coefficients for the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module kpi_coef (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kpi_pkg::coef_req_t req,
  output logic                    done,
  output kpi_pkg::coef_t          coef
);

  kpi_pkg::coef_state_t state, state_next;

  logic [kpi_pkg::TW-1:0] t, t2, t3, s;
  logic [8:0]             rem;
  logic [3:0]             cnt;
  logic [1:0]             mode;
  logic [7:0]             dur;

  logic [17:0] mul_a, mul_b;
  logic [35:0] mul_p;
  logic [kpi_pkg::TW-1:0] mul_rnd;
  logic [8:0]  rem2;
  logic        qbit;

  logic signed [kpi_pkg::CoefW-1:0] ts, t2s, t3s, ss, w;
  logic signed [kpi_pkg::CoefW-1:0] h00, h10, h01, h11;
  kpi_pkg::coef_t coef_next;

  always_comb begin
    mul_a = {1'b0, t};
    mul_b = {1'b0, t};
    case (state)
      kpi_pkg::CS_T3: mul_a = {1'b0, t2};
      kpi_pkg::CS_S: begin
        mul_a = {1'b0, t2};
        mul_b = 18'(18'd196608 - {t, 1'b0});
      end
      default: ;
    endcase
    mul_p   = {18'd0, mul_a} * {18'd0, mul_b};
    mul_rnd = kpi_pkg::TW'((mul_p + 36'd32768) >> 16);
    rem2    = {rem[7:0], 1'b0};
    qbit    = (rem2 >= {1'b0, dur});
  end

  always_comb begin
    ts  = $signed({5'd0, t});
    t2s = $signed({5'd0, t2});
    t3s = $signed({5'd0, t3});
    ss  = $signed({5'd0, s});
    w   = (mode == kpi_pkg::MODE_SMOOTH) ? ss : ts;
    h00 = kpi_pkg::CoefW'(2 * t3s - 3 * t2s + 65536);
    h10 = kpi_pkg::CoefW'(t3s - 2 * t2s + ts);
    h01 = kpi_pkg::CoefW'(3 * t2s - 2 * t3s);
    h11 = kpi_pkg::CoefW'(t3s - t2s);
    coef_next = '0;
    case (mode)
      kpi_pkg::MODE_LINEAR, kpi_pkg::MODE_SMOOTH: begin
        coef_next.c_0 = kpi_pkg::CoefW'(2 * (65536 - w));
        coef_next.c_1 = kpi_pkg::CoefW'(2 * w);
      end
      kpi_pkg::MODE_HERMITE: begin
        // The neighbor differences are spread over the four taps.
        coef_next.c_pp = kpi_pkg::CoefW'(-h10);
        coef_next.c_0  = kpi_pkg::CoefW'(2 * h00 - h11);
        coef_next.c_1  = kpi_pkg::CoefW'(2 * h01 + h10);
        coef_next.c_n  = h11;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kpi_pkg::CS_IDLE: begin
        if (req.start) begin
          if (req.dur == 8'd0 || req.tick >= req.dur) begin
            state_next = kpi_pkg::CS_T2;
          end else begin
            state_next = kpi_pkg::CS_DIV;
          end
        end
      end
      kpi_pkg::CS_DIV:  if (cnt == 4'd15) state_next = kpi_pkg::CS_T2;
      kpi_pkg::CS_T2:   state_next = kpi_pkg::CS_T3;
      kpi_pkg::CS_T3:   state_next = kpi_pkg::CS_S;
      kpi_pkg::CS_S:    state_next = kpi_pkg::CS_COEF;
      kpi_pkg::CS_COEF: state_next = kpi_pkg::CS_IDLE;
      default:          state_next = kpi_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpi_pkg::CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == kpi_pkg::CS_COEF);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      kpi_pkg::CS_IDLE: begin
        mode <= req.mode;
        dur  <= req.dur;
        rem  <= {1'b0, req.tick};
        cnt  <= 4'd0;
        if (req.dur == 8'd0) begin
          t <= '0;
        end else if (req.tick >= req.dur) begin
          t <= kpi_pkg::TW'(65536);
        end else begin
          t <= '0;
        end
      end
      kpi_pkg::CS_DIV: begin
        rem <= qbit ? 9'(rem2 - {1'b0, dur}) : rem2;
        t   <= {t[kpi_pkg::TW-2:0], qbit};
        cnt <= cnt + 4'd1;
      end
      kpi_pkg::CS_T2:   t2 <= mul_rnd;
      kpi_pkg::CS_T3:   t3 <= mul_rnd;
      kpi_pkg::CS_S:    s  <= mul_rnd;
      kpi_pkg::CS_COEF: coef <= coef_next;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for keyframe_pose_interpolator_top
// Loads the first keyframes of the table and then runs a directed table of
// beats and random beats. Every bone beat is checked against an in-bench
// interpolator. Both handshake sides idle at random, and one long output
// hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int NBONES = 11;
  localparam int NKEYS  = 16;
  localparam int NLOAD  = 4;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  kpi_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  kpi_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  keyframe_pose_interpolator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow of the keyframe table and the playback state.
  logic signed [15:0] key_angle [NKEYS][NBONES];
  logic signed [15:0] key_x [NKEYS];
  logic signed [15:0] key_y [NKEYS];
  logic [7:0]         key_dur [NKEYS];
  logic [1:0]         key_mode [NKEYS];
  logic [3:0]         play_key;
  logic [7:0]         play_tick;
  logic signed [15:0] pose_angle [NBONES];
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic [4:0]         key_count;

  kpi_pkg::out_item_t pose_q[$];
  int errors = 0;
  bit hold_req = 0;
  bit no_idle = 0;

  function automatic longint rhu(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] blend(logic [1:0] mode, longint pp, longint p0,
                                               longint p1, longint pn, longint t);
    longint t2, t3, s, h00, h10, h01, h11, acc;
    t2 = rhu(t * t, 16);
    t3 = rhu(t2 * t, 16);
    if (mode == kpi_pkg::MODE_LINEAR) return sat16(p0 + rhu((p1 - p0) * t, 16));
    if (mode == kpi_pkg::MODE_SMOOTH) begin
      s = rhu(t2 * (3 * 65536 - 2 * t), 16);
      return sat16(p0 + rhu((p1 - p0) * s, 16));
    end
    h00 = 2 * t3 - 3 * t2 + 65536;
    h10 = t3 - 2 * t2 + t;
    h01 = -2 * t3 + 3 * t2;
    h11 = t3 - t2;
    acc = 2 * h00 * p0 + h10 * (p1 - pp) + 2 * h01 * p1 + h11 * (pn - p0);
    return sat16(rhu(acc, 17));
  endfunction

  // Applies one accepted input beat and queues the bone beats it produces.
  function automatic void apply_beat(kpi_pkg::in_item_t it);
    int n, cur, prv, nxt, nxt2;
    longint t;
    logic [1:0] mode;
    kpi_pkg::out_item_t o;
    if (it.kind == kpi_pkg::KIND_ANGLE) begin
      if (it.bone_sel < NBONES) key_angle[it.frame_sel][it.bone_sel] = it.angle_value;
      return;
    end
    if (it.kind == kpi_pkg::KIND_HEADER) begin
      key_dur[it.frame_sel] = it.duration_value;
      key_mode[it.frame_sel] = it.interp_mode;
      key_x[it.frame_sel] = it.root_x;
      key_y[it.frame_sel] = it.root_y;
      return;
    end
    if (it.kind != kpi_pkg::KIND_TICK) return;
    n = key_count;
    if (n == 0) n = 1;
    if (n > NKEYS) n = NKEYS;
    if (play_key >= n) play_key = 0;
    cur = play_key;
    prv = (cur + n - 1) % n;
    nxt = (cur + 1) % n;
    nxt2 = (nxt + 1) % n;
    mode = key_mode[cur];
    if (key_dur[cur] == 0) t = 0;
    else begin
      t = (longint'(play_tick) <<< 16) / longint'(key_dur[cur]);
      if (t > 65536) t = 65536;
    end
    if (mode != kpi_pkg::MODE_HOLD) begin
      for (int b = 0; b < NBONES; b++)
        pose_angle[b] = blend(mode, key_angle[prv][b], key_angle[cur][b],
                              key_angle[nxt][b], key_angle[nxt2][b], t);
      if (mode != kpi_pkg::MODE_LINEAR) begin
        pose_x = blend(mode, key_x[prv], key_x[cur], key_x[nxt], key_x[nxt2], t);
        pose_y = blend(mode, key_y[prv], key_y[cur], key_y[nxt], key_y[nxt2], t);
      end
    end
    for (int b = 0; b < NBONES; b++) begin
      o.bone_index = b[3:0];
      o.bone_angle = pose_angle[b];
      o.last = (b == NBONES - 1);
      o.torso_x = o.last ? pose_x : 16'sd0;
      o.torso_y = o.last ? pose_y : 16'sd0;
      pose_q.push_back(o);
    end
    if (play_tick >= key_dur[cur]) begin
      play_key = nxt[3:0];
      play_tick = '0;
    end else begin
      play_tick = play_tick + 8'd1;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sends one beat; valid stays high afterwards so back-to-back beats need no toggle.
  task automatic send(kpi_pkg::in_item_t it);
    int gap;
    bit ok;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    apply_beat(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_count(logic [4:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {kpi_pkg::REG_KEYFRAME_COUNT, 2'b00};
    pwdata <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_count = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic kpi_pkg::in_item_t beat(logic [1:0] kind, logic [3:0] f, logic [3:0] b,
                                             logic [15:0] a, logic [7:0] d, logic [1:0] m,
                                             logic [15:0] x, logic [15:0] y);
    kpi_pkg::in_item_t it;
    it.kind = kind; it.frame_sel = f; it.bone_sel = b; it.angle_value = a;
    it.duration_value = d; it.interp_mode = m; it.root_x = x; it.root_y = y;
    return it;
  endfunction

  function automatic kpi_pkg::in_item_t rand_beat();
    kpi_pkg::in_item_t it;
    int r;
    it = beat(kpi_pkg::KIND_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              16'($urandom), 8'($urandom_range(0, 5)), 2'($urandom_range(0, 3)),
              16'($urandom), 16'($urandom));
    if ($urandom_range(0, 7) == 0) it.duration_value = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 4) it.kind = kpi_pkg::KIND_ANGLE;
    else if (r < 7) it.kind = kpi_pkg::KIND_HEADER;
    else if (r == 7) it.kind = KIND_UNUSED;
    return it;
  endfunction

  // Receiver: random hold-off per beat, one long hold-off on request.
  initial begin : receiver
    int n;
    bit got;
    kpi_pkg::out_item_t d, e;
    @(negedge rst);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        hold_req = 0;
        n = 600;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid && !out_stall;
        d = out_data;
        @(posedge clk);
      end while (!got);
      if (pose_q.size() == 0) begin
        report("unexpected bone beat, bone", d.bone_index, -1);
      end else begin
        e = pose_q.pop_front();
        if (d.bone_index !== e.bone_index) report("bone_index", d.bone_index, e.bone_index);
        if (d.bone_angle !== e.bone_angle) report("bone_angle", d.bone_angle, e.bone_angle);
        if (d.torso_x !== e.torso_x) report("torso_x", d.torso_x, e.torso_x);
        if (d.torso_y !== e.torso_y) report("torso_y", d.torso_y, e.torso_y);
        if (d.last !== e.last) report("last", d.last, e.last);
      end
    end
  end

  typedef struct {
    kpi_pkg::in_item_t it;
    bit                typed;
    int                angle0;
  } row_t;

  initial begin : stimulus
    row_t rows[$];
    int first;
    logic [4:0] counts [5];
    counts = '{5'd4, 5'd0, 5'd2, 5'd3, 5'd1};
    for (int k = 0; k < NKEYS; k++) begin
      for (int b = 0; b < NBONES; b++) key_angle[k][b] = '0;
      key_x[k] = '0; key_y[k] = '0; key_dur[k] = '0; key_mode[k] = '0;
    end
    for (int b = 0; b < NBONES; b++) pose_angle[b] = '0;
    play_key = '0; play_tick = '0; pose_x = '0; pose_y = '0; key_count = 5'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load the keyframes that ticks may reach; the count never exceeds NLOAD.
    for (int k = 0; k < NLOAD; k++) begin
      send(beat(kpi_pkg::KIND_HEADER, 4'(k), 4'd0, 16'd0, 8'd0, kpi_pkg::MODE_LINEAR,
                16'd0, 16'd0));
      for (int b = 0; b < NBONES; b++)
        send(beat(kpi_pkg::KIND_ANGLE, 4'(k), 4'(b), 16'd0, 8'd0, 2'd0, 16'd0, 16'd0));
    end

    rows = '{
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 0},
      '{beat(kpi_pkg::KIND_ANGLE, 0, 0, 16'h7fff, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_ANGLE, 0, 10, 16'h8000, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_ANGLE, 0, 11, 16'h1234, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_ANGLE, 15, 15, 16'h4321, 0, 0, 0, 0), 0, 0},
      '{beat(KIND_UNUSED, 15, 15, 16'hffff, 8'hff, 3, 16'hffff, 16'hffff), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 32767},
      '{beat(kpi_pkg::KIND_HEADER, 0, 0, 0, 0, kpi_pkg::MODE_HOLD, 16'h7fff, 16'h8000), 0, 0},
      '{beat(kpi_pkg::KIND_ANGLE, 0, 0, 16'h0100, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 32767},
      '{beat(kpi_pkg::KIND_HEADER, 0, 0, 0, 0, kpi_pkg::MODE_SMOOTH, 16'h7fff, 16'h8000), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 256},
      '{beat(kpi_pkg::KIND_HEADER, 0, 0, 0, 8'd4, kpi_pkg::MODE_HERMITE, 16'h0040, 16'hffc0),
        0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_HEADER, 0, 0, 0, 8'hff, kpi_pkg::MODE_LINEAR, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0},
      '{beat(kpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0}
    };
    foreach (rows[i]) begin
      send(rows[i].it);
      // The bone beats of this tick are the last ones queued.
      first = pose_q.size() - NBONES;
      if (rows[i].typed && pose_q[first].bone_angle != rows[i].angle0)
        report("directed bone 0 angle", pose_q[first].bone_angle, rows[i].angle0);
    end
    drain();

    // Random phases over several keyframe counts, zero included.
    counts[4] = 5'($urandom_range(1, NLOAD));
    for (int p = 0; p < 5; p++) begin
      write_count(counts[p]);
      no_idle = (p == 3);
      if (p == 1) hold_req = 1;
      for (int i = 0; i < 11; i++) send(rand_beat());
      drain();
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== keyframe_pose_interpolator_top.f =====
src/kpi_pkg.sv
src/kpi_ram.sv
src/kpi_coef.sv
src/keyframe_pose_interpolator_top.sv
dv/tb.sv
